// ===== rtl/framed_packet_deframer_unit_macros.svh =====
// Assertion macros for the frame deframer.
// Included by the top level; no other dependencies.
`ifndef FRAMED_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define FRAMED_PACKET_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define FPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define FPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define FPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/fpd_pkg.sv =====
// Shared types and constants for the frame deframer.
// No dependencies.
package fpd_pkg;

    localparam logic [7:0]  HDR_LOW_BYTE  = 8'hFF;
    localparam logic [7:0]  HDR_HIGH_BYTE = 8'hFE;
    localparam logic [23:0] MAX_LEN_RESET = 24'd4096;
    localparam logic [31:0] LEN_OVERHEAD  = 32'd4;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM   = 2'd1;
    localparam logic [1:0] STATUS_SHORT_LEN = 2'd2;
    localparam logic [1:0] STATUS_LONG_LEN  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] command_code;
        logic [23:0] payload_length;
        logic [1:0]  frame_status;
    } t_result;

endpackage

// ===== rtl/fpd_parser.sv =====
// Frame parse state and the per-byte next-state and result logic.
// Depends on fpd_pkg.
module fpd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_consume,
    input  logic [7:0]       i_byte,
    input  logic [23:0]      i_max_len,
    output logic             o_res_valid,
    output fpd_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN     = 3'd1,
        PH_CMD     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SUM     = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_hdr_seen, n_hdr_seen;
    logic [1:0]  r_idx, n_idx;
    logic [23:0] r_len_lo, n_len_lo;
    logic [15:0] r_cmd, n_cmd;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_rx_sum_lo, n_rx_sum_lo;
    logic [23:0] r_remain, n_remain;
    logic [23:0] r_plen, n_plen;

    logic [31:0] w_len;
    logic [31:0] w_len_m4;
    logic [23:0] w_remain_dec;

    assign w_len        = {i_byte, r_len_lo};
    assign w_len_m4     = w_len - fpd_pkg::LEN_OVERHEAD;
    assign w_remain_dec = r_remain - 24'd1;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_seen  = r_hdr_seen;
        n_idx       = r_idx;
        n_len_lo    = r_len_lo;
        n_cmd       = r_cmd;
        n_sum       = r_sum;
        n_rx_sum_lo = r_rx_sum_lo;
        n_remain    = r_remain;
        n_plen      = r_plen;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_LEN: begin
                case (r_idx)
                    2'd0: n_len_lo[7:0]   = i_byte;
                    2'd1: n_len_lo[15:8]  = i_byte;
                    2'd2: n_len_lo[23:16] = i_byte;
                    default: n_len_lo     = r_len_lo;
                endcase
                if (r_idx != 2'd3) begin
                    n_idx = r_idx + 2'd1;
                end else if (w_len < fpd_pkg::LEN_OVERHEAD) begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = fpd_pkg::KIND_END;
                    o_res.frame_status = fpd_pkg::STATUS_SHORT_LEN;
                    n_phase            = PH_HUNT;
                    n_hdr_seen         = 1'b0;
                    n_idx              = 2'd0;
                end else if (w_len > {8'd0, i_max_len}) begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = fpd_pkg::KIND_END;
                    o_res.frame_status = fpd_pkg::STATUS_LONG_LEN;
                    n_phase            = PH_HUNT;
                    n_hdr_seen         = 1'b0;
                    n_idx              = 2'd0;
                end else begin
                    n_remain = w_len_m4[23:0];
                    n_plen   = w_len_m4[23:0];
                    n_idx    = 2'd0;
                    n_cmd    = '0;
                    n_phase  = PH_CMD;
                end
            end
            PH_CMD: begin
                if (r_idx == 2'd0) begin
                    n_cmd = {8'd0, i_byte};
                    n_idx = 2'd1;
                end else begin
                    n_cmd   = {i_byte, r_cmd[7:0]};
                    n_idx   = 2'd0;
                    n_sum   = '0;
                    n_phase = (r_remain == 24'd0) ? PH_SUM : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum    = r_sum + {8'd0, i_byte};
                n_remain = w_remain_dec;
                if (w_remain_dec == 24'd0) begin
                    n_idx   = 2'd0;
                    n_phase = PH_SUM;
                end
                o_res_valid        = 1'b1;
                o_res.kind         = fpd_pkg::KIND_DATA;
                o_res.payload_byte = i_byte;
            end
            PH_SUM: begin
                if (r_idx == 2'd0) begin
                    n_rx_sum_lo = i_byte;
                    n_idx       = 2'd1;
                end else begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = fpd_pkg::KIND_END;
                    o_res.command_code   = r_cmd;
                    o_res.payload_length = r_plen;
                    o_res.frame_status   = ({i_byte, r_rx_sum_lo} == r_sum) ?
                                           fpd_pkg::STATUS_OK : fpd_pkg::STATUS_BAD_SUM;
                    n_phase              = PH_HUNT;
                    n_hdr_seen           = 1'b0;
                    n_idx                = 2'd0;
                end
            end
            default: begin
                // header hunt: FF arms, FE after FF starts a frame
                if (r_hdr_seen && i_byte == fpd_pkg::HDR_HIGH_BYTE) begin
                    n_hdr_seen = 1'b0;
                    n_idx      = 2'd0;
                    n_len_lo   = '0;
                    n_phase    = PH_LEN;
                end else begin
                    n_phase    = PH_HUNT;
                    n_hdr_seen = (i_byte == fpd_pkg::HDR_LOW_BYTE);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_hdr_seen  <= 1'b0;
            r_idx       <= 2'd0;
            r_len_lo    <= '0;
            r_cmd       <= '0;
            r_sum       <= '0;
            r_rx_sum_lo <= '0;
            r_remain    <= '0;
            r_plen      <= '0;
        end else if (i_consume) begin
            r_phase     <= n_phase;
            r_hdr_seen  <= n_hdr_seen;
            r_idx       <= n_idx;
            r_len_lo    <= n_len_lo;
            r_cmd       <= n_cmd;
            r_sum       <= n_sum;
            r_rx_sum_lo <= n_rx_sum_lo;
            r_remain    <= n_remain;
            r_plen      <= n_plen;
        end
    end

endmodule

// ===== rtl/fpd_out_fifo.sv =====
// Two-entry result queue that decouples the parser from output stalls.
// Depends on fpd_pkg.
module fpd_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fpd_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_can_push,
    output logic             o_valid,
    output fpd_pkg::t_result o_data
);

    fpd_pkg::t_result r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_pop;

    assign o_can_push = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_data     = r_mem[r_rd_ptr];
    assign w_pop      = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/framed_packet_deframer_unit.sv =====
// Top level of the frame deframer: input holding register, parser, result queue.
// Depends on fpd_pkg, fpd_parser, fpd_out_fifo and the assertion macro header.
//
//   channel   direction  handshake                    payload
//   in        sink       i_in_valid / o_in_stall      i_rx_byte
//   out       source     o_out_valid / i_out_stall    o_result_kind .. o_frame_status
//   cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_data (max frame length)
//
// One byte per cycle sustained while the result queue has room; each byte is registered in the
// input holding register and its result in the queue, from which the result is presented.
// The parse step is one level of logic between the input register and the queue.
// Reset clears the parse state and sets the length limit to 4096.
// An output stall is absorbed by the two-entry queue; input stalls only when it fills.
`include "framed_packet_deframer_unit_macros.svh"

module framed_packet_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_command_code,
    output logic [23:0] o_payload_length,
    output logic [1:0]  o_frame_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte;
    logic [23:0]      r_max_len;
    logic             w_can_push;
    logic             w_consume;
    logic             w_res_valid;
    logic             w_push;
    logic             w_in_xfer;
    logic             w_out_data;
    fpd_pkg::t_result w_res;
    fpd_pkg::t_result w_out;

    assign o_cfg_ready = 1'b1;
    assign w_consume   = r_in_valid && w_can_push;
    assign o_in_stall  = r_in_valid && !w_can_push;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_push      = w_consume && w_res_valid;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_xfer) begin
            n_in_valid = 1'b1;
        end else if (w_consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max_len  <= fpd_pkg::MAX_LEN_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    // hold the byte while the queue is full
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= i_rx_byte;
        end
    end

    fpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_consume   (w_consume),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    fpd_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_res),
        .i_pop      (!i_out_stall),
        .o_can_push (w_can_push),
        .o_valid    (o_out_valid),
        .o_data     (w_out)
    );

    assign o_result_kind    = w_out.kind;
    assign o_payload_byte   = w_out.payload_byte;
    assign o_command_code   = w_out.command_code;
    assign o_payload_length = w_out.payload_length;
    assign o_frame_status   = w_out.frame_status;

    assign w_out_data = o_out_valid && (o_result_kind == fpd_pkg::KIND_DATA);

    `FPD_ASSERT_NEXT(a_held_byte_stable, i_clk, i_rst_n, o_in_stall, $stable(r_in_byte))
    `FPD_ASSERT_NEXT(a_push_shows_valid, i_clk, i_rst_n, w_push, o_out_valid)
    `FPD_ASSERT_NOW(a_data_status_ok, i_clk, i_rst_n, w_out_data, o_frame_status == fpd_pkg::STATUS_OK)

endmodule

// ===== tb/sv/tb_framed_packet_deframer_unit.sv =====
// Self-checking testbench for framed_packet_deframer_unit: drives a byte stream of frames,
// noise and damaged frames, predicts every payload byte and frame status and compares them.
// Depends on fpd_pkg and the framed_packet_deframer_unit RTL.
module tb_framed_packet_deframer_unit;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_COMMAND,
        PH_PAYLOAD,
        PH_CHECKSUM
    } t_parse_phase;

    // Byte-level frame tracker: predicts results and matches them against the block.
    class t_deframe_checker;
        logic [23:0]      max_len;
        t_parse_phase     phase;
        bit               armed;
        int unsigned      idx;
        logic [31:0]      len_word;
        logic [15:0]      cmd_word;
        logic [15:0]      run_sum;
        logic [15:0]      got_sum;
        logic [23:0]      remaining;
        fpd_pkg::t_result awaited[$];
        int               errors;
        int               bytes_in;
        int               data_out;
        int               ends_by_status[4];

        function new();
            max_len   = fpd_pkg::MAX_LEN_RESET;
            phase     = PH_HUNT;
            armed     = 1'b0;
            idx       = 0;
            len_word  = '0;
            cmd_word  = '0;
            run_sum   = '0;
            got_sum   = '0;
            remaining = '0;
            errors    = 0;
            bytes_in  = 0;
            data_out  = 0;
            foreach (ends_by_status[i]) ends_by_status[i] = 0;
        endfunction

        function void restart_hunt();
            phase = PH_HUNT;
            armed = 1'b0;
            idx   = 0;
        endfunction

        function void take_byte(logic [7:0] b);
            fpd_pkg::t_result r;
            bit               hit;
            r   = '0;
            hit = 1'b0;
            bytes_in++;
            case (phase)
                PH_LENGTH: begin
                    len_word[idx*8 +: 8] = b;
                    if (idx < 3) begin
                        idx++;
                    end else if (len_word < fpd_pkg::LEN_OVERHEAD) begin
                        r.kind         = fpd_pkg::KIND_END;
                        r.frame_status = fpd_pkg::STATUS_SHORT_LEN;
                        hit            = 1'b1;
                        restart_hunt();
                    end else if (len_word > {8'h00, max_len}) begin
                        r.kind         = fpd_pkg::KIND_END;
                        r.frame_status = fpd_pkg::STATUS_LONG_LEN;
                        hit            = 1'b1;
                        restart_hunt();
                    end else begin
                        remaining = 24'(len_word - fpd_pkg::LEN_OVERHEAD);
                        idx       = 0;
                        cmd_word  = '0;
                        phase     = PH_COMMAND;
                    end
                end
                PH_COMMAND: begin
                    if (idx == 0) begin
                        cmd_word = {8'h00, b};
                        idx      = 1;
                    end else begin
                        cmd_word[15:8] = b;
                        idx            = 0;
                        run_sum        = '0;
                        got_sum        = '0;
                        phase          = (remaining == 0) ? PH_CHECKSUM : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    run_sum   = run_sum + b;
                    remaining = remaining - 24'd1;
                    if (remaining == 0) begin
                        idx   = 0;
                        phase = PH_CHECKSUM;
                    end
                    r.kind         = fpd_pkg::KIND_DATA;
                    r.payload_byte = b;
                    hit            = 1'b1;
                end
                PH_CHECKSUM: begin
                    if (idx == 0) begin
                        got_sum = {8'h00, b};
                        idx     = 1;
                    end else begin
                        got_sum[15:8]    = b;
                        r.kind           = fpd_pkg::KIND_END;
                        r.command_code   = cmd_word;
                        r.payload_length = 24'(len_word - fpd_pkg::LEN_OVERHEAD);
                        r.frame_status   = (got_sum == run_sum) ?
                                           fpd_pkg::STATUS_OK : fpd_pkg::STATUS_BAD_SUM;
                        hit              = 1'b1;
                        restart_hunt();
                    end
                end
                default: begin
                    if (armed && b == fpd_pkg::HDR_HIGH_BYTE) begin
                        armed    = 1'b0;
                        idx      = 0;
                        len_word = '0;
                        phase    = PH_LENGTH;
                    end else begin
                        phase = PH_HUNT;
                        armed = (b == fpd_pkg::HDR_LOW_BYTE);
                    end
                end
            endcase
            if (hit) awaited.push_back(r);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] seen);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, seen);
        endfunction

        function void check_result(fpd_pkg::t_result got);
            fpd_pkg::t_result want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d byte 0x%0h %s",
                         $time, got.kind, got.payload_byte,
                         $sformatf("status %0d", got.frame_status));
                return;
            end
            want = awaited.pop_front();
            if (want.kind == fpd_pkg::KIND_DATA) data_out++;
            else ends_by_status[want.frame_status]++;
            if (got.kind !== want.kind)
                report("result_kind", want.kind, got.kind);
            if (got.payload_byte !== want.payload_byte)
                report("payload_byte", want.payload_byte, got.payload_byte);
            if (got.command_code !== want.command_code)
                report("command_code", want.command_code, got.command_code);
            if (got.payload_length !== want.payload_length)
                report("payload_length", want.payload_length, got.payload_length);
            if (got.frame_status !== want.frame_status)
                report("frame_status", want.frame_status, got.frame_status);
        endfunction

        function void check_leftovers();
            fpd_pkg::t_result want;
            while (awaited.size() != 0) begin
                want = awaited.pop_front();
                errors++;
                $display("%0t: missing result, expected kind %0d byte 0x%0h status %0d, %s",
                         $time, want.kind, want.payload_byte, want.frame_status,
                         "actual none");
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [23:0] i_cfg_data  = 24'h0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_result_kind;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_command_code;
    logic [23:0] o_payload_length;
    logic [1:0]  o_frame_status;
    logic        o_cfg_ready;

    t_deframe_checker sb;
    t_deframe_checker lookahead;   // tracks the parser at generation time
    logic [7:0]       tx_q[$];
    bit               in_calm  = 1'b0;
    bit               out_calm = 1'b0;
    int               cycles   = 0;
    int               settings_used = 1;

    framed_packet_deframer_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_payload_byte   (o_payload_byte),
        .o_command_code   (o_command_code),
        .o_payload_length (o_payload_length),
        .o_frame_status   (o_frame_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Monitor: every transfer on each channel is sampled at the edge that completes it.
    always @(posedge i_clk) begin : monitor
        fpd_pkg::t_result seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.max_len = i_cfg_data;
            if (i_in_valid && !o_in_stall) sb.take_byte(i_rx_byte);
            if (o_out_valid && !i_out_stall) begin
                seen.kind           = o_result_kind;
                seen.payload_byte   = o_payload_byte;
                seen.command_code   = o_command_code;
                seen.payload_length = o_payload_length;
                seen.frame_status   = o_frame_status;
                sb.check_result(seen);
            end
        end
    end

    // Result side: stall a random number of cycles ahead of each transfer.
    initial begin
        int unsigned n;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 40) == 0) out_calm = !out_calm;
            n = out_calm ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = in_calm ? 0 : $urandom_range(0, 17);
        lookahead.take_byte(b);
        lookahead.awaited.delete();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_queue();
        while (tx_q.size() > 0) send_byte(tx_q.pop_front());
    endtask

    // Hold the input until every predicted result has been seen.
    task automatic hold_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    task automatic write_limit(input logic [23:0] v);
        hold_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lookahead.max_len = v;
        settings_used++;
    endtask

    function automatic void add_le(logic [31:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++) tx_q.push_back(v[8*i +: 8]);
    endfunction

    // Noise never carries the header's second byte, so it cannot open a frame by itself.
    function automatic void add_noise(int nbytes);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++) begin
            b = 8'($urandom);
            if (b == fpd_pkg::HDR_HIGH_BYTE) b = fpd_pkg::HDR_LOW_BYTE;
            tx_q.push_back(b);
        end
    endfunction

    function automatic void add_frame(logic [31:0] len, bit bad_sum, bit all_ones);
        logic [15:0] sum;
        logic [7:0]  b;
        logic [31:0] i;
        tx_q.push_back(fpd_pkg::HDR_LOW_BYTE);
        tx_q.push_back(fpd_pkg::HDR_HIGH_BYTE);
        add_le(len, 4);
        if (len < fpd_pkg::LEN_OVERHEAD || len > {8'h00, lookahead.max_len}) return;
        add_le($urandom, 2);
        sum = '0;
        for (i = 0; i < len - fpd_pkg::LEN_OVERHEAD; i++) begin
            b = all_ones ? 8'hFF : 8'($urandom);
            sum = sum + b;
            tx_q.push_back(b);
        end
        if (bad_sum) sum = sum ^ 16'(1 << $urandom_range(0, 15));
        add_le({16'h0, sum}, 2);
    endfunction

    function automatic logic [31:0] over_length(logic [23:0] lim);
        if (lim != 24'hFF_FFFF && $urandom_range(0, 1) == 1)
            return {8'h00, lim} + 32'd1 + $urandom_range(0, 40);
        return $urandom | 32'h0100_0000;
    endfunction

    task automatic run_random(input int target, input bit allow_cut);
        int          made;
        int          k;
        int          cut;
        int unsigned maxp;
        logic [31:0] len;
        made = 0;
        while (made < target) begin
            if ($urandom_range(0, 30) == 0) in_calm = !in_calm;
            if ($urandom_range(0, 80) == 0) hold_for_results();
            if ($urandom_range(0, 6) == 0) begin
                add_noise($urandom_range(1, 4));
                send_queue();
            end
            k = $urandom_range(0, 99);
            if (k < 8) begin
                len = $urandom_range(0, 3);
            end else if (k < 16) begin
                len = over_length(lookahead.max_len);
            end else begin
                maxp = (lookahead.max_len < 4) ? 0 : lookahead.max_len - 4;
                if ($urandom_range(0, 24) == 0) begin
                    if (maxp > 300) maxp = 300;
                end else if (maxp > 20) begin
                    maxp = 20;
                end
                len = fpd_pkg::LEN_OVERHEAD + $urandom_range(0, maxp);
            end
            add_frame(len, $urandom_range(0, 4) == 0, 1'b0);
            // drop the tail so the next frame lands inside this one
            if (allow_cut && $urandom_range(0, 19) == 0) begin
                cut = $urandom_range(1, tx_q.size() - 1);
                while (tx_q.size() > cut) void'(tx_q.pop_back());
            end
            made += tx_q.size();
            send_queue();
        end
        // pad until the parser is back in header search
        while (lookahead.phase != PH_HUNT) send_byte(8'h00);
    endtask

    initial begin : stimulus
        logic [23:0] lim_seq[6];
        int          target_seq[6];
        sb        = new();
        lookahead = new();
        lim_seq    = '{fpd_pkg::MAX_LEN_RESET, 24'd4, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0};
        lim_seq[4] = $urandom_range(20, 300);
        lim_seq[5] = $urandom_range(4, 40);
        target_seq = '{200, 80, 120, 60, 180, 160};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 6; p++) begin
            if (p > 0) write_limit(lim_seq[p]);
            in_calm = (p == 2);
            if (p == 0) begin
                // stray second byte, re-armed header with empty payload, short length,
                // length one over the reset limit, two-byte payload with a bad checksum
                tx_q = {fpd_pkg::HDR_HIGH_BYTE, 8'h5A, fpd_pkg::HDR_LOW_BYTE,
                        fpd_pkg::HDR_LOW_BYTE, fpd_pkg::HDR_HIGH_BYTE,
                        8'h04, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
                        fpd_pkg::HDR_LOW_BYTE, fpd_pkg::HDR_HIGH_BYTE,
                        8'h03, 8'h00, 8'h00, 8'h00,
                        fpd_pkg::HDR_LOW_BYTE, fpd_pkg::HDR_HIGH_BYTE,
                        8'h01, 8'h10, 8'h00, 8'h00,
                        fpd_pkg::HDR_LOW_BYTE, fpd_pkg::HDR_HIGH_BYTE,
                        8'h06, 8'h00, 8'h00, 8'h00,
                        8'h34, 8'h12, 8'hFF, 8'h80, 8'h7E, 8'h01};
            end else if (lim_seq[p] == 24'hFF_FFFF) begin
                // lengths beyond 24 bits, and a checksum that wraps
                add_frame(32'h0100_0000, 1'b0, 1'b0);
                add_frame(32'hFFFF_FFFF, 1'b0, 1'b0);
                add_frame(32'd304, 1'b0, 1'b1);
            end else if (lim_seq[p] >= 4 && lim_seq[p] <= 300) begin
                add_frame({8'h00, lim_seq[p]}, 1'b0, 1'b0);
                add_frame({8'h00, lim_seq[p]} + 32'd1, 1'b0, 1'b0);
            end else begin
                add_frame(32'd4, 1'b0, 1'b0);
            end
            send_queue();
            run_random(target_seq[p], lim_seq[p] <= fpd_pkg::MAX_LEN_RESET);
        end

        hold_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_leftovers();

        $display("Run: %0d bytes in, %0d payload bytes out, %0d ok / %0d bad-sum frames",
                 sb.bytes_in, sb.data_out, sb.ends_by_status[fpd_pkg::STATUS_OK],
                 sb.ends_by_status[fpd_pkg::STATUS_BAD_SUM]);
        $display("Run: %0d short / %0d over-limit frames, %0d limit settings incl. 0, 4, %s",
                 sb.ends_by_status[fpd_pkg::STATUS_SHORT_LEN],
                 sb.ends_by_status[fpd_pkg::STATUS_LONG_LEN], settings_used, "16777215");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpd_pkg.sv
rtl/fpd_parser.sv
rtl/fpd_out_fifo.sv
rtl/framed_packet_deframer_unit.sv
tb/sv/tb_framed_packet_deframer_unit.sv
